// File: src/edd_pkg.sv
package edd_pkg;

   // covered span of years, starting at the base year
   localparam int YEAR_SPAN = 256;
   localparam int BASE_YEAR = 1970;
   localparam int COUNT_MAX = 131071;

   localparam int COUNT_W = 17;
   localparam int ACC_W   = COUNT_W + 1;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int LEN_W   = 9;

   // first year past the span, one bit wider than the year field
   localparam logic [YEAR_W:0] YEAR_END = (YEAR_W + 1)'(BASE_YEAR + YEAR_SPAN);

   // residues of the base year for the leap-year counters
   localparam logic [1:0] BASE_MOD4   = 2'(BASE_YEAR % 4);
   localparam logic [6:0] BASE_MOD100 = 7'(BASE_YEAR % 100);
   localparam logic [8:0] BASE_MOD400 = 9'(BASE_YEAR % 400);

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_SPAN    = 2'd2;

   // conversion direction
   localparam logic MODE_TO_COUNT = 1'b0;
   localparam logic MODE_TO_DATE  = 1'b1;

   // year tracker control and status
   typedef struct packed {
      logic load;
      logic step;
   } edd_yr_ctl_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic              leap;
   } edd_yr_stat_type;

   // index of the last day of the span, limited to the count range
   function automatic logic [COUNT_W-1:0] span_last_day();
      int total;
      int y;
      total = 0;
      for (y = BASE_YEAR; y < BASE_YEAR + YEAR_SPAN; y++) begin
         if (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) begin
            total = total + 366;
         end else begin
            total = total + 365;
         end
         if (total > COUNT_MAX) begin
            return COUNT_W'(COUNT_MAX);
         end
      end
      return COUNT_W'(total - 1);
   endfunction

   localparam logic [COUNT_W-1:0] LAST_DAY = span_last_day();

   // length of a month, zero for codes that are no month
   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// File: src/edd_alu.sv
// shared add/subtract unit with a greater-or-equal compare
module edd_alu (
   input  logic [edd_pkg::ACC_W-1:0] a,
   input  logic [edd_pkg::LEN_W-1:0] b,
   input  logic                      sub,
   output logic [edd_pkg::ACC_W-1:0] res,
   output logic                      ge
);

   logic [edd_pkg::ACC_W:0] b_ext;
   logic [edd_pkg::ACC_W:0] sum;

   // one adder serves both directions; when subtracting, the sign of the difference gives the compare
   assign b_ext = {{(edd_pkg::ACC_W + 1 - edd_pkg::LEN_W){1'b0}}, b};
   assign sum   = sub ? ({1'b0, a} + ~b_ext + 1'b1) : ({1'b0, a} + b_ext);
   assign res   = sum[edd_pkg::ACC_W-1:0];
   assign ge    = sub ? !sum[edd_pkg::ACC_W] : ({1'b0, a} >= b_ext);

endmodule

// File: src/edd_year_track.sv
// running year with residue counters for the leap-year rule
module edd_year_track (
   input  logic                     clock,
   input  edd_pkg::edd_yr_ctl_type  ctl,
   output edd_pkg::edd_yr_stat_type stat
);

   logic [edd_pkg::YEAR_W-1:0] year_ff, year_in;
   logic [1:0]                 mod4_ff, mod4_in;
   logic [6:0]                 mod100_ff, mod100_in;
   logic [8:0]                 mod400_ff, mod400_in;

   // next year and residues
   always_comb begin
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      if (ctl.load) begin
         year_in   = edd_pkg::YEAR_W'(edd_pkg::BASE_YEAR);
         mod4_in   = edd_pkg::BASE_MOD4;
         mod100_in = edd_pkg::BASE_MOD100;
         mod400_in = edd_pkg::BASE_MOD400;
      end else if (ctl.step) begin
         year_in   = year_ff + 1'b1;
         mod4_in   = mod4_ff + 1'b1;
         mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 1'b1;
         mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
   end

   // divisible by 4 and not by 100, or by 400
   assign stat.year = year_ff;
   assign stat.leap = (mod4_ff == 2'd0) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));

endmodule

// File: src/epoch_day_date_converter.sv
// Converts between a Gregorian date and the count of days since 1970-01-01 over a
// span of edd_pkg::YEAR_SPAN years (256, so 1970..2225). tuser selects the direction:
// 0 takes year, month and day and returns the day count, 1 takes a day count and
// returns year, month and day. Status 1 flags a bad month or day, status 2 a date
// outside the span or a count past the last day of the span (the count saturates at
// that last day). One word is converted at a time: the shared adder steps once per
// year from 1970 and then once per month; words rejected at once skip both. A new word
// is taken while the previous result waits, and the one after it stalls until that
// result is read.
module epoch_day_date_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // year[11:0], month[15:12], day[20:16], day_count[37:21], zero fill
   input  logic [39:0] req_tdata,
   // mode[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_day_count[16:0], out_year[28:17], out_month[32:29], out_day[37:33],
   // status[39:38]
   output logic [39:0] rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEARS,
      ST_CHECK,
      ST_MONTHS,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic                               mode_ff, mode_in;
   logic [edd_pkg::YEAR_W-1:0]         year_ff, year_in;
   logic [edd_pkg::MONTH_W-1:0]        month_ff, month_in;
   logic [edd_pkg::DAY_W-1:0]          day_ff, day_in;
   logic [edd_pkg::ACC_W-1:0]          acc_ff, acc_in;
   logic                               ovf_ff, ovf_in;
   logic [1:0]                         st_ff, st_in;
   logic [edd_pkg::MONTH_W-1:0]        mon_ff, mon_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]                        rsp_data_ff, rsp_data_in;

   edd_pkg::edd_yr_ctl_type            yr_ctl;
   edd_pkg::edd_yr_stat_type           yr_stat;

   logic [edd_pkg::LEN_W-1:0]          alu_b;
   logic                               alu_sub;
   logic [edd_pkg::ACC_W-1:0]          alu_res;
   logic                               alu_ge;

   logic                               accept;
   logic [edd_pkg::YEAR_W-1:0]         req_year;
   logic [edd_pkg::MONTH_W-1:0]        req_month;
   logic [edd_pkg::DAY_W-1:0]          req_day;
   logic [edd_pkg::COUNT_W-1:0]        req_count;
   logic [edd_pkg::LEN_W-1:0]          year_len;
   logic [edd_pkg::DAY_W-1:0]          cur_mdays;
   logic                               last_month;
   logic                               year_reached;
   logic [edd_pkg::DAY_W-1:0]          out_day;

   assign req_year  = req_tdata[11:0];
   assign req_month = req_tdata[15:12];
   assign req_day   = req_tdata[20:16];
   assign req_count = req_tdata[37:21];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // year and month lengths from the tracker
   assign year_len     = yr_stat.leap ? 9'd366 : 9'd365;
   assign cur_mdays    = edd_pkg::month_days(yr_stat.leap, mon_ff);
   assign last_month   = (mon_ff == month_ff);
   assign year_reached = (yr_stat.year == year_ff);

   // operand select for the shared adder
   always_comb begin
      alu_sub = (mode_ff == edd_pkg::MODE_TO_DATE);
      alu_b   = year_len;
      if (state_ff == ST_MONTHS) begin
         if ((mode_ff == edd_pkg::MODE_TO_COUNT) && last_month) begin
            alu_b = edd_pkg::LEN_W'(day_ff - 1'b1);
         end else begin
            alu_b = edd_pkg::LEN_W'(cur_mdays);
         end
      end
   end

   edd_alu u_alu (
      .a   (acc_ff),
      .b   (alu_b),
      .sub (alu_sub),
      .res (alu_res),
      .ge  (alu_ge)
   );

   // tracker restarts at the base year on each word
   assign yr_ctl.load = accept;
   assign yr_ctl.step = (state_ff == ST_YEARS) &&
                        (((mode_ff == edd_pkg::MODE_TO_COUNT) && !year_reached) ||
                         ((mode_ff == edd_pkg::MODE_TO_DATE) && alu_ge));

   edd_year_track u_year_track (
      .clock (clock),
      .ctl   (yr_ctl),
      .stat  (yr_stat)
   );

   assign out_day = acc_ff[edd_pkg::DAY_W-1:0] + 1'b1;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      st_in         = st_ff;
      mon_in        = mon_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_tuser;
               year_in  = req_year;
               month_in = req_month;
               day_in   = req_day;
               acc_in   = '0;
               ovf_in   = 1'b0;
               st_in    = edd_pkg::STATUS_OK;
               state_in = ST_YEARS;
               if (req_tuser == edd_pkg::MODE_TO_DATE) begin
                  if (req_count > edd_pkg::LAST_DAY) begin
                     acc_in = edd_pkg::ACC_W'(edd_pkg::LAST_DAY);
                     st_in  = edd_pkg::STATUS_SPAN;
                  end else begin
                     acc_in = edd_pkg::ACC_W'(req_count);
                  end
               end else if (req_year < edd_pkg::YEAR_W'(edd_pkg::BASE_YEAR)) begin
                  st_in    = edd_pkg::STATUS_SPAN;
                  state_in = ST_FINISH;
               end else if ({1'b0, req_year} >= edd_pkg::YEAR_END) begin
                  acc_in   = edd_pkg::ACC_W'(edd_pkg::LAST_DAY);
                  st_in    = edd_pkg::STATUS_SPAN;
                  state_in = ST_FINISH;
               end else if ((req_month < 4'd1) || (req_month > 4'd12) ||
                            (req_day == 5'd0)) begin
                  st_in    = edd_pkg::STATUS_INVALID;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_YEARS: begin
            if (mode_ff == edd_pkg::MODE_TO_COUNT) begin
               if (year_reached) begin
                  state_in = ST_CHECK;
               end else if (!ovf_ff) begin
                  if (alu_res[edd_pkg::ACC_W-1]) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = alu_res;
                  end
               end
            end else if (alu_ge) begin
               acc_in = alu_res;
            end else begin
               mon_in   = 4'd1;
               state_in = ST_MONTHS;
            end
         end
         ST_CHECK: begin
            // day past the end of the month
            if (day_ff > edd_pkg::month_days(yr_stat.leap, month_ff)) begin
               acc_in   = '0;
               st_in    = edd_pkg::STATUS_INVALID;
               state_in = ST_FINISH;
            end else begin
               mon_in   = 4'd1;
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            if (mode_ff == edd_pkg::MODE_TO_COUNT) begin
               if (last_month) begin
                  if (ovf_ff || alu_res[edd_pkg::ACC_W-1]) begin
                     acc_in = edd_pkg::ACC_W'(edd_pkg::COUNT_MAX);
                     st_in  = edd_pkg::STATUS_SPAN;
                  end else begin
                     acc_in = alu_res;
                  end
                  state_in = ST_FINISH;
               end else begin
                  mon_in = mon_ff + 1'b1;
                  if (!ovf_ff) begin
                     if (alu_res[edd_pkg::ACC_W-1]) begin
                        ovf_in = 1'b1;
                     end else begin
                        acc_in = alu_res;
                     end
                  end
               end
            end else if ((mon_ff < 4'd12) && alu_ge) begin
               acc_in = alu_res;
               mon_in = mon_ff + 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output word to be free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               if (mode_ff == edd_pkg::MODE_TO_COUNT) begin
                  rsp_data_in = {st_ff, 21'd0, acc_ff[edd_pkg::COUNT_W-1:0]};
               end else begin
                  rsp_data_in = {st_ff, out_day, mon_ff, yr_stat.year,
                                 {edd_pkg::COUNT_W{1'b0}}};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mode_ff     <= mode_in;
      year_ff     <= year_in;
      month_ff    <= month_in;
      day_ff      <= day_in;
      acc_ff      <= acc_in;
      ovf_ff      <= ovf_in;
      st_ff       <= st_in;
      mon_ff      <= mon_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status code three is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:38] != 2'd3))
      else $error("undefined status code on result word");

   // a result month is either unused or a real month
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[32:29] <= 4'd12))
      else $error("result month out of range");

   // an accepted word keeps the input closed for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input reopened right after accept");

   // a new result only comes out of the finishing step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FINISH))
      else $error("result word raised outside the finishing step");

endmodule
